// ----- sv/scfsc_pkg.sv -----
`default_nettype none

package scfsc_pkg;

  localparam int unsigned FRAME_BYTES = 26;
  localparam int unsigned IDX_W = $clog2(FRAME_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0] FIRST_PAYLOAD_IDX = IDX_W'(3);

  localparam int unsigned JOB_DEPTH_DEFAULT = 2;

  localparam logic [7:0] SYNC_BYTE         = 8'hAA;
  localparam logic [7:0] REPLY_TYPE_STATUS = 8'h12;
  localparam logic [7:0] RSP_OK            = 8'h80;
  localparam logic [7:0] RSP_SUM_ERROR     = 8'h90;
  localparam logic [7:0] RSP_BAD_PARAM     = 8'hA0;
  localparam logic [7:0] RSP_UNKNOWN_CMD   = 8'hB0;
  localparam logic [7:0] RSP_INVALID_CMD   = 8'hC0;
  localparam logic [7:0] CMD_SET_VOLTAGE   = 8'h23;
  localparam logic [7:0] CMD_SET_CURRENT   = 8'h24;
  localparam logic [15:0] TIMEOUT_RESET    = 16'd1000;

  typedef enum logic [1:0] {
    ACT_SEND = 2'd0,
    ACT_RX   = 2'd1,
    ACT_TICK = 2'd2
  } action_e;

  typedef enum logic [0:0] {
    CFG_DEVICE_ADDRESS = 1'b0,
    CFG_REPLY_TIMEOUT  = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    STAT_OK          = 4'd0,
    STAT_BAD_SUM     = 4'd1,
    STAT_NOT_STATUS  = 4'd2,
    STAT_REMOTE_SUM  = 4'd3,
    STAT_BAD_PARAM   = 4'd4,
    STAT_UNKNOWN_CMD = 4'd5,
    STAT_INVALID_CMD = 4'd6,
    STAT_OTHER       = 4'd7,
    STAT_TIMEOUT     = 4'd8
  } status_e;

  typedef struct packed {
    logic        is_frame;
    logic [7:0]  addr;
    logic [7:0]  cmd;
    logic [31:0] payload;
    status_e     code;
  } job_t;

endpackage

`default_nettype wire

// ----- sv/supply_command_framer_status_checker_unit.sv -----
// Path: an accepted item that yields a job is written into the job queue; its first
// beat is then loaded into the output register when that register is free.
// Throughput: one item per cycle; a send yields 26 beats, one per cycle unless pop is
// held off, set by the frame emitter's byte counter. Received bytes and ticks are
// handled in the front end; a status report is one beat. Input stalls while the job queue is full.
// Reset: asynchronous, clears queue and reply state; address 0, timeout 1000.
`default_nettype none

module supply_command_framer_status_checker_unit import scfsc_pkg::*; #(
  parameter int unsigned JOB_DEPTH = JOB_DEPTH_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  action_i,
  input  wire logic [7:0]  command_code_i,
  input  wire logic [31:0] payload_value_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             result_kind_o,
  output logic [7:0]       tx_byte_o,
  output logic             last_of_frame_o,
  output logic [3:0]       status_code_o,
  output logic             command_accepted_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);

  job_t job_w, job_r;
  logic job_push, job_pop, job_valid, job_full;

  assign full = job_full;

  scfsc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (push && !job_full),
    .action_i        (action_i),
    .command_code_i  (command_code_i),
    .payload_value_i (payload_value_i),
    .rx_byte_i       (rx_byte_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .job_o           (job_w),
    .job_push_o      (job_push)
  );

  scfsc_job_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_w),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .rdata_o (job_r),
    .valid_o (job_valid)
  );

  scfsc_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .job_i              (job_r),
    .job_valid_i        (job_valid),
    .job_pop_o          (job_pop),
    .empty              (empty),
    .pop                (pop),
    .result_kind_o      (result_kind_o),
    .tx_byte_o          (tx_byte_o),
    .last_of_frame_o    (last_of_frame_o),
    .status_code_o      (status_code_o),
    .command_accepted_o (command_accepted_o)
  );

endmodule

`default_nettype wire

// ----- sv/scfsc_front.sv -----
`default_nettype none

module scfsc_front import scfsc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [1:0]  action_i,
  input  wire logic [7:0]  command_code_i,
  input  wire logic [31:0] payload_value_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  output job_t             job_o,
  output logic             job_push_o
);

  logic [7:0]       addr_q, addr_d;
  logic [15:0]      timeout_q, timeout_d;
  logic             awaiting_q, awaiting_d;
  logic [IDX_W-1:0] count_q, count_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       type_q, type_d;
  logic [7:0]       status_q, status_d;
  logic [15:0]      elapsed_q, elapsed_d;
  logic [15:0]      elapsed_inc;
  status_e          rx_code;

  always_comb begin
    if (sum_q != rx_byte_i) begin
      rx_code = STAT_BAD_SUM;
    end else if (type_q != REPLY_TYPE_STATUS) begin
      rx_code = STAT_NOT_STATUS;
    end else begin
      unique case (status_q)
        RSP_SUM_ERROR:   rx_code = STAT_REMOTE_SUM;
        RSP_BAD_PARAM:   rx_code = STAT_BAD_PARAM;
        RSP_UNKNOWN_CMD: rx_code = STAT_UNKNOWN_CMD;
        RSP_INVALID_CMD: rx_code = STAT_INVALID_CMD;
        RSP_OK:          rx_code = STAT_OK;
        default:         rx_code = STAT_OTHER;
      endcase
    end
  end

  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;

  always_comb begin
    addr_d     = addr_q;
    timeout_d  = timeout_q;
    awaiting_d = awaiting_q;
    count_d    = count_q;
    sum_d      = sum_q;
    type_d     = type_q;
    status_d   = status_q;
    elapsed_d  = elapsed_q;
    job_push_o = 1'b0;
    job_o.is_frame = 1'b0;
    job_o.addr     = addr_q;
    job_o.cmd      = command_code_i;
    job_o.payload  = payload_value_i;
    job_o.code     = rx_code;

    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEVICE_ADDRESS: addr_d = cfg_wdata_i[7:0];
        CFG_REPLY_TIMEOUT:  timeout_d = cfg_wdata_i;
        default: ;
      endcase
    end

    if (accept_i) begin
      unique case (action_e'(action_i))
        ACT_SEND: begin
          job_push_o     = 1'b1;
          job_o.is_frame = 1'b1;
          awaiting_d     = 1'b1;
          count_d        = '0;
          sum_d          = '0;
          type_d         = '0;
          status_d       = '0;
          elapsed_d      = '0;
        end
        ACT_RX: begin
          if (awaiting_q) begin
            if (count_q >= LAST_IDX) begin
              job_push_o = 1'b1;
              awaiting_d = 1'b0;
              count_d    = '0;
              sum_d      = '0;
              type_d     = '0;
              status_d   = '0;
              elapsed_d  = '0;
            end else begin
              sum_d   = sum_q + rx_byte_i;
              count_d = count_q + IDX_W'(1);
              if (count_q == IDX_W'(2)) type_d = rx_byte_i;
              if (count_q == IDX_W'(3)) status_d = rx_byte_i;
            end
          end
        end
        ACT_TICK: begin
          if (awaiting_q) begin
            if (elapsed_inc >= timeout_q) begin
              job_push_o = 1'b1;
              job_o.code = STAT_TIMEOUT;
              awaiting_d = 1'b0;
              count_d    = '0;
              sum_d      = '0;
              type_d     = '0;
              status_d   = '0;
              elapsed_d  = '0;
            end else begin
              elapsed_d = elapsed_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q     <= '0;
      timeout_q  <= TIMEOUT_RESET;
      awaiting_q <= 1'b0;
      count_q    <= '0;
      sum_q      <= '0;
      type_q     <= '0;
      status_q   <= '0;
      elapsed_q  <= '0;
    end else begin
      addr_q     <= addr_d;
      timeout_q  <= timeout_d;
      awaiting_q <= awaiting_d;
      count_q    <= count_d;
      sum_q      <= sum_d;
      type_q     <= type_d;
      status_q   <= status_d;
      elapsed_q  <= elapsed_d;
    end
  end

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !awaiting_q |-> (count_q == '0 && elapsed_q == '0 && sum_q == '0))
    else $error("idle with reply state left over");

  a_send_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && action_i == ACT_SEND) |=> (awaiting_q && count_q == '0))
    else $error("send did not restart the wait");

endmodule

`default_nettype wire

// ----- sv/scfsc_job_fifo.sv -----
`default_nettype none

module scfsc_job_fifo import scfsc_pkg::*; #(
  parameter int unsigned DEPTH = JOB_DEPTH_DEFAULT
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      wdata_i,
  output logic      full_o,
  input  wire logic pop_i,
  output job_t      rdata_o,
  output logic      valid_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) wptr_d = (wptr_q == PTR_LAST) ? '0 : wptr_q + PTR_W'(1);
    if (do_pop)  rptr_d = (rptr_q == PTR_LAST) ? '0 : rptr_q + PTR_W'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CNT_W'(1);
    if (do_pop && !do_push) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/scfsc_back.sv -----
`default_nettype none

module scfsc_back import scfsc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  job_t             job_i,
  input  wire logic        job_valid_i,
  output logic             job_pop_o,
  output logic             empty,
  input  wire logic        pop,
  output logic             result_kind_o,
  output logic [7:0]       tx_byte_o,
  output logic             last_of_frame_o,
  output logic [3:0]       status_code_o,
  output logic             command_accepted_o
);

  logic             out_valid_q, out_valid_d;
  logic             kind_q, kind_d;
  logic [7:0]       tx_q, tx_d;
  logic             last_q, last_d;
  logic [3:0]       code_q, code_d;
  logic             ok_q, ok_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       sum_q, sum_d;
  logic             advance;
  logic [2:0]       plen;
  logic [IDX_W-1:0] off;
  logic [7:0]       pay_byte;
  logic [7:0]       frame_byte;

  assign advance = !out_valid_q || pop;
  assign off     = idx_q - FIRST_PAYLOAD_IDX;

  always_comb begin
    case (job_i.cmd)
      CMD_SET_VOLTAGE: plen = 3'd4;
      CMD_SET_CURRENT: plen = 3'd2;
      default:         plen = 3'd1;
    endcase
  end

  always_comb begin
    case (off[1:0])
      2'd0:    pay_byte = job_i.payload[7:0];
      2'd1:    pay_byte = job_i.payload[15:8];
      2'd2:    pay_byte = job_i.payload[23:16];
      default: pay_byte = job_i.payload[31:24];
    endcase
  end

  always_comb begin
    if (idx_q == '0) begin
      frame_byte = SYNC_BYTE;
    end else if (idx_q == IDX_W'(1)) begin
      frame_byte = job_i.addr;
    end else if (idx_q == IDX_W'(2)) begin
      frame_byte = job_i.cmd;
    end else if (idx_q == LAST_IDX) begin
      frame_byte = sum_q;
    end else if (idx_q >= FIRST_PAYLOAD_IDX && off < IDX_W'(plen)) begin
      frame_byte = pay_byte;
    end else begin
      frame_byte = 8'h00;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    tx_d        = tx_q;
    last_d      = last_q;
    code_d      = code_q;
    ok_d        = ok_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    job_pop_o   = 1'b0;
    if (advance) begin
      out_valid_d = job_valid_i;
      if (job_valid_i) begin
        if (job_i.is_frame) begin
          kind_d = 1'b0;
          tx_d   = frame_byte;
          last_d = (idx_q == LAST_IDX);
          code_d = STAT_OK;
          ok_d   = 1'b0;
          if (idx_q == LAST_IDX) begin
            idx_d     = '0;
            sum_d     = '0;
            job_pop_o = 1'b1;
          end else begin
            idx_d = idx_q + IDX_W'(1);
            sum_d = sum_q + frame_byte;
          end
        end else begin
          kind_d    = 1'b1;
          tx_d      = 8'h00;
          last_d    = 1'b0;
          code_d    = job_i.code;
          ok_d      = (job_i.code == STAT_OK);
          job_pop_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      sum_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    tx_q   <= tx_d;
    last_q <= last_d;
    code_q <= code_d;
    ok_q   <= ok_d;
  end

  assign empty              = !out_valid_q;
  assign result_kind_o      = kind_q;
  assign tx_byte_o          = tx_q;
  assign last_of_frame_o    = last_q;
  assign status_code_o      = code_q;
  assign command_accepted_o = ok_q;

  a_frame_holds_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0) |-> (job_valid_i && job_i.is_frame))
    else $error("frame in progress without its job");

  a_last_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && job_valid_i && job_i.is_frame && idx_q == LAST_IDX)
      |=> (out_valid_q && last_q && idx_q == '0))
    else $error("closing frame beat not flagged");

endmodule

`default_nettype wire
